[rtl/core/uigfb_pkg.sv]
// shared types and constants for the uart idle-gap frame buffer
package uigfb_pkg;

  // input command codes
  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_TICK = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_NOTICE = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_EMPTY  = 2'd2,
    KIND_RSVD   = 2'd3
  } kind_t;

  localparam int unsigned CMD_W       = 2;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned TIMER_W     = 8;
  localparam int unsigned RESULT_CAP  = 32;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam logic [7:0]  IDLE_LIMIT_RESET = 8'd30;
  localparam logic [7:0]  TIMER_MAX        = 8'hFF;

endpackage

[rtl/core/uart_idle_gap_frame_buffer_unit.sv]
// top level of the uart idle-gap frame buffer
// Received bytes (cmd 0) are appended to a BUFFER_DEPTH-entry buffer ram and
// dropped once it is full. Tick words (cmd 1) carry elapsed milliseconds; while
// the buffer holds bytes and the count has not moved since the previous tick,
// an idle timer adds them up (saturating at 255) and, the first time it reaches
// idle_limit_ms (register 0, reset 30), one frame-complete notice word is sent
// with the current byte count. A read word (cmd 2) returns up to
// min(max_len, count, 32) buffered bytes, one output word per byte with last on
// the final one, or a single empty-read word; the count and pending flag clear.
// A read of n bytes holds the input stalled through its drain and any output
// stall: the buffer ram's single read port delivers one byte per cycle while
// the output register is free, with its first read issued in the accept cycle.
// Results sit in an output register, so a word is taken whenever the block is
// idle and that register is free or being emptied. The buffer ram is never
// cleared; only entries below the count are read. No clearing pass.
module uart_idle_gap_frame_buffer_unit #(
  parameter int unsigned BUFFER_DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [uigfb_pkg::CMD_W-1:0]       in_cmd,
  input  logic [uigfb_pkg::BYTE_W-1:0]      in_rx_byte,
  input  logic [uigfb_pkg::TIMER_W-1:0]     in_tick_ms,
  input  logic [uigfb_pkg::BYTE_W-1:0]      in_max_len,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [uigfb_pkg::KIND_W-1:0]      out_kind,
  output logic [uigfb_pkg::BYTE_W-1:0]      out_data,
  output logic [uigfb_pkg::LEN_W-1:0]       out_frame_len,
  output logic                              out_last,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [uigfb_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [uigfb_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [uigfb_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                              pready
);

  import uigfb_pkg::*;

  // count holds 0..BUFFER_DEPTH, ram address holds 0..BUFFER_DEPTH-1
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       byte_count_r, byte_count_nxt;
  logic [CW-1:0]       count_at_tick_r, count_at_tick_nxt;
  logic [TIMER_W-1:0]  idle_time_r, idle_time_nxt;
  logic                frame_pending_r, frame_pending_nxt;
  logic [TIMER_W-1:0]  idle_limit_r;

  // drain progress: index of the byte now on the ram read data
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [LEN_W-1:0]    n_r, n_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [BYTE_W-1:0]   out_data_r, out_data_nxt;
  logic [LEN_W-1:0]    out_frame_len_r, out_frame_len_nxt;
  logic                out_last_r, out_last_nxt;

  // buffer ram access
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [BYTE_W-1:0]   ram_rdata;

  logic                in_accept;
  logic                out_free;
  logic                buf_full;
  logic [TIMER_W:0]    idle_sum;
  logic [TIMER_W-1:0]  idle_sat;
  logic [8:0]          len9;
  logic [8:0]          cnt9;
  logic [8:0]          take9;
  logic [LEN_W-1:0]    take_n;
  logic [LEN_W-1:0]    idx_inc;
  logic                cfg_wr;

  // configuration port: register 0 at byte address 0, anything at 4 and up is ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == 1'b0) ? {{(CFG_DATA_W-TIMER_W){1'b0}}, idle_limit_r}
                                     : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_limit_r <= IDLE_LIMIT_RESET;
    end else if (cfg_wr && (paddr[2] == 1'b0)) begin
      idle_limit_r <= pwdata[TIMER_W-1:0];
    end
  end

  // handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;

  assign buf_full  = (byte_count_r == CW'(BUFFER_DEPTH));

  // saturating idle timer sum
  assign idle_sum  = {1'b0, idle_time_r} + {1'b0, in_tick_ms};
  assign idle_sat  = idle_sum[TIMER_W] ? TIMER_MAX : idle_sum[TIMER_W-1:0];

  // bytes returned by a read: min(max_len, count, result cap)
  assign len9   = {1'b0, in_max_len};
  assign cnt9   = 9'(byte_count_r);
  assign take9  = (len9 < cnt9) ? len9 : cnt9;
  assign take_n = (take9 > 9'(RESULT_CAP)) ? LEN_W'(RESULT_CAP) : take9[LEN_W-1:0];

  assign idx_inc = {1'b0, idx_r} + LEN_W'(1);

  always_comb begin
    state_nxt          = state_r;
    byte_count_nxt     = byte_count_r;
    count_at_tick_nxt  = count_at_tick_r;
    idle_time_nxt      = idle_time_r;
    frame_pending_nxt  = frame_pending_r;
    idx_nxt            = idx_r;
    n_nxt              = n_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_kind_nxt       = out_kind_r;
    out_data_nxt       = out_data_r;
    out_frame_len_nxt  = out_frame_len_r;
    out_last_nxt       = out_last_r;
    ram_we             = 1'b0;
    ram_waddr          = AW'(byte_count_r);
    ram_re             = 1'b0;
    ram_raddr          = '0;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          case (in_cmd)
            CMD_BYTE: begin
              // append unless full; a full buffer drops the byte
              if (!buf_full) begin
                ram_we         = 1'b1;
                byte_count_nxt = byte_count_r + CW'(1);
              end
            end
            CMD_TICK: begin
              if (byte_count_r == '0) begin
                count_at_tick_nxt = '0;
              end else if (count_at_tick_r != byte_count_r) begin
                // bytes arrived since the last tick: restart the idle timer
                count_at_tick_nxt = byte_count_r;
                idle_time_nxt     = '0;
              end else if (idle_time_r < idle_limit_r) begin
                idle_time_nxt = idle_sat;
                if (idle_sat >= idle_limit_r) begin
                  frame_pending_nxt = 1'b1;
                  out_valid_nxt     = 1'b1;
                  out_kind_nxt      = KIND_NOTICE;
                  out_data_nxt      = '0;
                  out_frame_len_nxt = LEN_W'(byte_count_r);
                  out_last_nxt      = 1'b1;
                end
              end
            end
            CMD_READ: begin
              byte_count_nxt    = '0;
              frame_pending_nxt = 1'b0;
              if (take_n == '0) begin
                out_valid_nxt     = 1'b1;
                out_kind_nxt      = KIND_EMPTY;
                out_data_nxt      = '0;
                out_frame_len_nxt = '0;
                out_last_nxt      = 1'b1;
              end else begin
                // first ram read goes out in the accept cycle
                ram_re    = 1'b1;
                ram_raddr = '0;
                idx_nxt   = '0;
                n_nxt     = take_n;
                state_nxt = S_DRAIN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DRAIN: begin
        // ram read data holds while the output register is blocked
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_kind_nxt      = KIND_DATA;
          out_data_nxt      = ram_rdata;
          out_frame_len_nxt = n_r;
          out_last_nxt      = (idx_inc == n_r);
          if (idx_inc == n_r) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = AW'(idx_inc);
            idx_nxt   = IDX_W'(idx_inc);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      byte_count_r    <= '0;
      count_at_tick_r <= '0;
      idle_time_r     <= '0;
      frame_pending_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      byte_count_r    <= byte_count_nxt;
      count_at_tick_r <= count_at_tick_nxt;
      idle_time_r     <= idle_time_nxt;
      frame_pending_r <= frame_pending_nxt;
      out_valid_r     <= out_valid_nxt;
    end
    idx_r           <= idx_nxt;
    n_r             <= n_nxt;
    out_kind_r      <= out_kind_nxt;
    out_data_r      <= out_data_nxt;
    out_frame_len_r <= out_frame_len_nxt;
    out_last_r      <= out_last_nxt;
  end

  uigfb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_buf_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_rx_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_data      = out_data_r;
  assign out_frame_len = out_frame_len_r;
  assign out_last      = out_last_r;

  // a pending frame always has bytes behind it
  a_pending_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    frame_pending_r |-> (byte_count_r != '0))
    else $error("frame pending with empty buffer");

  // count never runs past the buffer depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= CW'(BUFFER_DEPTH))
    else $error("byte count beyond buffer depth");

  // drain index stays inside the requested length
  a_drain_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> (({1'b0, idx_r}) < n_r))
    else $error("drain index out of range");

  // an accepted read empties the buffer count
  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_cmd == CMD_READ)) |=> (byte_count_r == '0))
    else $error("read did not clear byte count");

  // no byte word is written to the ram while a drain is in progress
  a_no_write_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> !ram_we)
    else $error("ram write during drain");

endmodule

[rtl/core/uigfb_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
module uigfb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[dv/tb_uart_idle_gap_frame_buffer_unit.sv]
// self-checking testbench for the uart idle-gap frame buffer unit
module tb_uart_idle_gap_frame_buffer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import uigfb_pkg::*;

  localparam int unsigned BUFFER_DEPTH = 32;
  // register 0 sits at byte address 0
  localparam logic [CFG_ADDR_W-1:0] IDLE_LIMIT_ADDR = 3'd0;
  localparam int unsigned FRAME_BUDGET = 58;

  // one result word as the block emits it
  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  flen;
    logic              last;
  } result_t;

  // one row of the directed script; typed rows carry their single result
  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  rx;
    logic [7:0]  ms;
    logic [7:0]  ml;
    logic        typed;
    kind_t       kind;
    logic [5:0]  flen;
  } script_row_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_cmd = CMD_NONE;
  logic [BYTE_W-1:0]     in_rx_byte = '0;
  logic [TIMER_W-1:0]    in_tick_ms = '0;
  logic [BYTE_W-1:0]     in_max_len = '0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [KIND_W-1:0]     out_kind;
  logic [BYTE_W-1:0]     out_data;
  logic [LEN_W-1:0]      out_frame_len;
  logic                  out_last;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  uart_idle_gap_frame_buffer_unit #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_rx_byte    (in_rx_byte),
    .in_tick_ms    (in_tick_ms),
    .in_max_len    (in_max_len),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_data      (out_data),
    .out_frame_len (out_frame_len),
    .out_last      (out_last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // predicted state of the frame buffer, mirrors the block after reset
  // ---------------------------------------------------------------------
  logic [7:0] rx_copy [BUFFER_DEPTH];
  int         held = 0;           // bytes in the buffer
  int         held_at_tick = 0;   // byte count seen by the previous tick
  int         idle_ms = 0;        // accumulated idle time, saturates at 255
  bit         frame_pending = 1'b0;
  int         idle_limit = IDLE_LIMIT_RESET;

  result_t    owed_words[$];      // result words the block still owes
  int         mismatches = 0;
  int         burst_left = 0;

  task automatic note_mismatch(input string what);
    if (mismatches < 30) $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // advance the predicted buffer by one accepted word; queue the results
  // it causes unless the caller supplies its own
  function automatic void advance_frame_buffer(input cmd_t c, input logic [7:0] rx,
                                               input logic [7:0] ms, input logic [7:0] ml,
                                               input bit keep);
    int n;
    case (c)
      CMD_BYTE: begin
        // full buffer drops the byte
        if (held < BUFFER_DEPTH) begin
          rx_copy[held] = rx;
          held++;
        end
      end
      CMD_TICK: begin
        if (held == 0) begin
          held_at_tick = 0;
        end else if (held_at_tick != held) begin
          // count moved: restart the idle timer, no time added
          held_at_tick = held;
          idle_ms = 0;
        end else if (idle_ms < idle_limit) begin
          idle_ms += int'(ms);
          if (idle_ms > int'(TIMER_MAX)) idle_ms = int'(TIMER_MAX);
          if (idle_ms >= idle_limit) begin
            frame_pending = 1'b1;
            if (keep) owed_words.push_back('{KIND_NOTICE, 8'h00, LEN_W'(held), 1'b1});
          end
        end
      end
      CMD_READ: begin
        n = int'(ml);
        if (n > held) n = held;
        if (n > int'(RESULT_CAP)) n = RESULT_CAP;
        held = 0;
        frame_pending = 1'b0;
        if (n == 0) begin
          if (keep) owed_words.push_back('{KIND_EMPTY, 8'h00, LEN_W'(0), 1'b1});
        end else if (keep) begin
          for (int i = 0; i < n; i++)
            owed_words.push_back('{KIND_DATA, rx_copy[i], LEN_W'(n), (i + 1 == n)});
        end
      end
      default: ;  // unknown command is ignored
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // sender: drives one word, waits for it to be taken, then maybe idles
  // ---------------------------------------------------------------------
  task automatic offer_word(input cmd_t c, input logic [7:0] rx, input logic [7:0] ms,
                            input logic [7:0] ml, input bit typed = 1'b0,
                            input result_t typed_word = '0);
    int gap;
    in_valid   <= 1'b1;
    in_cmd     <= c;
    in_rx_byte <= rx;
    in_tick_ms <= ms;
    in_max_len <= ml;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
    advance_frame_buffer(c, rx, ms, ml, !typed);
    if (typed) owed_words.push_back(typed_word);
    // bursts of back-to-back words separated by random gaps
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(16, 0);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // drop valid and wait until every owed word has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_words.size() != 0) @(posedge clk);
    // a trailing byte or tick may still be in flight
    repeat (8) @(posedge clk);
  endtask

  // apb write of the idle limit: setup cycle then access cycle
  task automatic write_idle_limit(input logic [7:0] ms);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= IDLE_LIMIT_ADDR;
    pwdata  <= CFG_DATA_W'(ms);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    idle_limit = int'(ms);
  endtask

  // well-formed frames: a run of bytes, a few ticks, then a read;
  // stray words of any command are sprinkled in as noise
  task automatic run_frames(input int budget, input bit overfill);
    int         sent;
    int         nb;
    int         nt;
    cmd_t       stray;
    logic [7:0] ms;
    logic [7:0] ml;
    sent = 0;
    while (sent < budget) begin
      if (overfill) nb = $urandom_range(40, 33);
      else if ($urandom_range(9, 0) == 0) nb = $urandom_range(40, 28);
      else nb = $urandom_range(8, 0);
      overfill = 1'b0;
      repeat (nb) begin
        offer_word(CMD_BYTE, 8'($urandom), 8'($urandom), 8'($urandom));
        sent++;
      end
      nt = $urandom_range(8, 0);
      repeat (nt) begin
        if ($urandom_range(9, 0) == 0) begin
          stray = cmd_t'($urandom_range(3, 0));
          offer_word(stray, 8'($urandom), 8'($urandom), 8'($urandom));
          if (stray != CMD_NONE) sent++;
        end
        // mostly small steps so the limit is reached over several ticks
        if ($urandom_range(3, 0) == 0) ms = 8'($urandom);
        else ms = 8'($urandom_range(idle_limit / 4 + 1, 0));
        offer_word(CMD_TICK, 8'($urandom), ms, 8'($urandom));
        sent++;
      end
      case ($urandom_range(5, 0))
        0:       ml = 8'd0;
        1:       ml = 8'd255;
        2:       ml = 8'($urandom_range(4, 1));
        default: ml = 8'($urandom_range(40, 0));
      endcase
      offer_word(CMD_READ, 8'($urandom), 8'($urandom), ml);
      sent++;
    end
  endtask

  function automatic script_row_t row(input cmd_t c, input int rx, input int ms,
                                      input int ml, input bit typed = 1'b0,
                                      input kind_t k = KIND_NOTICE, input int flen = 0);
    row = '{c, rx[7:0], ms[7:0], ml[7:0], typed, k, flen[5:0]};
  endfunction

  // ---------------------------------------------------------------------
  // receiver: stall pattern changes mode at the end of each randomly sized phase
  // ---------------------------------------------------------------------
  int         stall_phase = 0;
  int         stall_mode = 0;
  logic [7:0] stall_mask = '0;

  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_mode  = $urandom_range(3, 0);
      stall_mask  = 8'($urandom);
      stall_phase = $urandom_range(64, 8);
    end
    stall_phase--;
    case (stall_mode)
      0:       out_stall <= 1'b0;                           // free flowing
      1:       out_stall <= ($urandom_range(99, 0) < 40);   // light random
      2:       out_stall <= stall_mask[stall_phase % 8];    // repeating mask
      default: out_stall <= ($urandom_range(99, 0) < 85);   // heavy back-pressure
    endcase
  end

  // ---------------------------------------------------------------------
  // result checker: every taken word against the oldest owed word
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_words.size() == 0) begin
        note_mismatch($sformatf("unexpected word kind %0d data %02h len %0d last %0b",
                                out_kind, out_data, out_frame_len, out_last));
      end else begin
        want = owed_words.pop_front();
        if (out_kind != want.kind)
          note_mismatch($sformatf("kind %0d, want %0d", out_kind, want.kind));
        if (out_data != want.data)
          note_mismatch($sformatf("data %02h, want %02h", out_data, want.data));
        if (out_frame_len != want.flen)
          note_mismatch($sformatf("frame_len %0d, want %0d", out_frame_len, want.flen));
        if (out_last != want.last)
          note_mismatch($sformatf("last %0b, want %0b", out_last, want.last));
      end
    end
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    script_row_t script[$];
    int          limits[6];

    // directed walk at the reset idle limit of 30
    script.push_back(row(CMD_READ, 0, 0, 255, 1'b1, KIND_EMPTY, 0)); // read after reset
    script.push_back(row(CMD_TICK, 0, 255, 0));           // tick on an empty buffer
    script.push_back(row(CMD_BYTE, 0, 0, 0));
    script.push_back(row(CMD_BYTE, 255, 255, 255));
    script.push_back(row(CMD_TICK, 0, 0, 0));             // count moved, timer restarts
    script.push_back(row(CMD_TICK, 0, 0, 0));             // zero elapsed time
    script.push_back(row(CMD_TICK, 0, 29, 0));            // one short of the limit
    script.push_back(row(CMD_TICK, 0, 1, 0, 1'b1, KIND_NOTICE, 2)); // exactly at it
    script.push_back(row(CMD_TICK, 0, 255, 0));           // already past, no second notice
    script.push_back(row(CMD_NONE, 255, 255, 255));       // unknown command
    script.push_back(row(CMD_READ, 0, 0, 0, 1'b1, KIND_EMPTY, 0));  // zero length read
    script.push_back(row(CMD_BYTE, 'hA5, 0, 0));
    script.push_back(row(CMD_BYTE, 'h5A, 0, 0));
    script.push_back(row(CMD_BYTE, 'h3C, 0, 0));
    script.push_back(row(CMD_TICK, 0, 7, 0));
    script.push_back(row(CMD_TICK, 0, 255, 0, 1'b1, KIND_NOTICE, 3)); // timer jumps to its 255 maximum
    script.push_back(row(CMD_BYTE, 'h81, 0, 0));          // byte after a notice
    script.push_back(row(CMD_TICK, 0, 0, 0));
    script.push_back(row(CMD_TICK, 0, 40, 0, 1'b1, KIND_NOTICE, 4));
    script.push_back(row(CMD_READ, 0, 0, 2));             // partial read
    script.push_back(row(CMD_BYTE, 'h42, 0, 0));
    script.push_back(row(CMD_READ, 0, 0, 255));           // max_len beyond the count
    script.push_back(row(CMD_READ, 0, 0, 128, 1'b1, KIND_EMPTY, 0));

    // limit 0 keeps the timer from ever counting, so no notices in that phase
    limits = '{1, 255, 0, $urandom_range(254, 2), $urandom_range(254, 2), 30};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i])
      offer_word(script[i].cmd, script[i].rx, script[i].ms, script[i].ml, script[i].typed,
                 '{script[i].kind, 8'h00, script[i].flen, 1'b1});

    foreach (limits[p]) begin
      settle();
      write_idle_limit(limits[p][7:0]);
      // the first phase opens with a frame that overflows the buffer
      run_frames(FRAME_BUDGET, p == 0);
    end

    settle();
    if (mismatches == 0) begin
      $display("uart_idle_gap_frame_buffer_unit test passed");
    end else begin
      $display("uart_idle_gap_frame_buffer_unit test failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("uart_idle_gap_frame_buffer_unit test failed");
    $finish;
  end

endmodule
